@@ rtl/sdl_pkg.sv @@
// Shared types, constants and activation helpers for the stacked dense layer.
`default_nettype none
package sdl_pkg;
    localparam int MaxInputs = 64;
    localparam int MaxNodes  = 64;
    localparam int Depth     = 4;

    localparam int InW    = $clog2(MaxInputs);
    localparam int NodeW  = $clog2(MaxNodes);
    localparam int StackW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int FillW  = $clog2(MaxInputs + 1);
    localparam int NcW    = $clog2(MaxNodes + 1);
    localparam int WAddrW = 2 * StackW + InW + NodeW;
    localparam int BAddrW = StackW + NodeW;
    localparam int AccW   = 40;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_STACK  = 2'd2;
    localparam logic [1:0] OP_PUSH   = 2'd3;

    localparam logic [1:0] ACT_SIGMOID  = 2'd0;
    localparam logic [1:0] ACT_TANH     = 2'd1;
    localparam logic [1:0] ACT_RELU     = 2'd2;
    localparam logic [1:0] ACT_IDENTITY = 2'd3;

    localparam logic CFG_ACT   = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // Takes a 2-bit stack field modulo the stack depth.
    function automatic logic [StackW-1:0] stack_mod(input logic [1:0] s);
        logic [1:0] m;
        m = 2'(32'(s) % Depth);
        return StackW'(m);
    endfunction

    // Piecewise-linear sigmoid over a Q.12 value of any sign.
    function automatic logic signed [17:0] plan_sigmoid(input logic signed [AccW-1:0] x);
        logic [AccW-1:0] a;
        logic [15:0] p;
        a = x[AccW-1] ? AccW'(-x) : AccW'(x);
        if (a >= AccW'(20480))     p = 16'd4096;
        else if (a >= AccW'(9728)) p = 16'(a[14:5]) + 16'd3456;
        else if (a >= AccW'(4096)) p = 16'(a[13:3]) + 16'd2560;
        else                       p = 16'(a[11:2]) + 16'd2048;
        return x[AccW-1] ? 18'sd4096 - $signed({2'b00, p}) : $signed({2'b00, p});
    endfunction

    // Saturates to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] x);
        if (x > AccW'(32767))       return 16'sh7fff;
        else if (x < -AccW'(32768)) return 16'sh8000;
        else                        return x[15:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/sdl_mac.sv @@
// Shared multiply-accumulate unit with a registered product stage.
`default_nettype none
module sdl_mac (
    input  wire logic                              aclk,
    input  wire logic                              clr,
    input  wire logic                              en,
    input  wire logic signed [15:0]                a,
    input  wire logic signed [15:0]                b,
    output logic signed [sdl_pkg::AccW-1:0]        acc
);
    logic signed [31:0]               prod_reg;
    logic                             pv_reg;
    logic signed [sdl_pkg::AccW-1:0]  acc_reg;

    // Product is registered before it is summed.
    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        pv_reg   <= en;
        if (clr) begin
            acc_reg <= '0;
        end else if (pv_reg) begin
            acc_reg <= acc_reg + sdl_pkg::AccW'(prod_reg);
        end
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

@@ rtl/stacked_dense_layer_forward_top.sv @@
// Top level of the stacked dense layer forward pass.
// Weight, bias and stack writes and non-final pushes are taken while the block is
// idle with no result waiting. A push marked last starts a pass that runs the single
// shared multiply-accumulate unit once per node and input: each node steps through
// its inputs, a closing sequencer step, the drain of the buffer read, weight read,
// product and accumulate pipeline, bias and rounding, activation and advance. A pass
// lasts longer while a result waits in the output register, and the block takes no
// requests meanwhile.
// Each result is held in an output register until taken. Configuration writes
// are taken at any time and must only be issued while the block is idle.
`default_nettype none
module stacked_dense_layer_forward_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [1:0]  s_from_stack,
    input  wire logic [1:0]  s_to_stack,
    input  wire logic [5:0]  s_src_index,
    input  wire logic [5:0]  s_node_index,
    input  wire logic signed [15:0] s_value,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_node_out,
    output logic signed [15:0] m_activation,
    output logic             m_final_res
);
    localparam int AccW = sdl_pkg::AccW;
    localparam int InW = sdl_pkg::InW;
    localparam int NodeW = sdl_pkg::NodeW;
    localparam int StackW = sdl_pkg::StackW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_D1   = 3'd2;
    localparam logic [2:0] ST_D2   = 3'd3;
    localparam logic [2:0] ST_ACT  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_D0   = 3'd6;

    logic [2:0] state_reg;
    logic [1:0] act_sel_reg;
    logic [sdl_pkg::NcW-1:0] node_count_reg;
    logic [sdl_pkg::FillW-1:0] fill_reg;
    logic [sdl_pkg::FillW-1:0] j_reg;
    logic [NodeW-1:0] node_reg;
    logic [StackW-1:0] nstack [sdl_pkg::MaxNodes];
    logic [sdl_pkg::MaxNodes-1:0] nstack_v_reg;
    logic signed [15:0] in_mem [sdl_pkg::MaxInputs];
    logic [StackW-1:0] in_stk [sdl_pkg::MaxInputs];
    logic signed [15:0] w_mem [2**sdl_pkg::WAddrW];
    logic signed [15:0] b_mem [2**sdl_pkg::BAddrW];
    logic signed [15:0] w_rd_reg, x_rd_reg, x_b_reg, b_rd_reg;
    logic [StackW-1:0] stk_rd_reg, istk_rd_reg;
    logic stk_ok_reg;
    logic [InW-1:0] jd_reg;
    logic rd_a_reg, rd_v_reg, clr;
    logic signed [AccW-1:0] acc, sum_reg;
    logic signed [15:0] act_reg;
    logic out_v_reg, out_last_reg;
    logic [NodeW-1:0] out_node_reg;
    logic [sdl_pkg::NcW-1:0] n_eff;
    logic s_fire, in_fire;
    logic [StackW-1:0] fs, ts, cur_st;
    logic [InW-1:0] jx;

    assign n_eff = (node_count_reg > sdl_pkg::NcW'(sdl_pkg::MaxNodes))
                   ? sdl_pkg::NcW'(sdl_pkg::MaxNodes) : node_count_reg;
    assign s_ready = (state_reg == ST_IDLE) && !out_v_reg;
    assign s_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign fs = sdl_pkg::stack_mod(s_from_stack);
    assign ts = sdl_pkg::stack_mod(s_to_stack);
    assign cur_st = stk_ok_reg ? stk_rd_reg : '0;
    assign jx = j_reg[InW-1:0];
    assign in_fire = s_fire && s_op == sdl_pkg::OP_PUSH;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_sel_reg <= sdl_pkg::ACT_SIGMOID;
            node_count_reg <= sdl_pkg::NcW'(64);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sdl_pkg::CFG_ACT:   act_sel_reg <= cfg_data[1:0];
                sdl_pkg::CFG_COUNT: node_count_reg <= sdl_pkg::NcW'(cfg_data);
                default: ;
            endcase
        end
    end

    // Weight and bias memories, written by requests and read by the sequencer.
    always_ff @(posedge aclk) begin
        if (s_fire && s_op == sdl_pkg::OP_WEIGHT)
            w_mem[{fs, ts, s_src_index[InW-1:0], s_node_index[NodeW-1:0]}] <= s_value;
        if (s_fire && s_op == sdl_pkg::OP_BIAS)
            b_mem[{ts, s_node_index[NodeW-1:0]}] <= s_value;
        w_rd_reg <= w_mem[{istk_rd_reg, cur_st, jd_reg, node_reg}];
        b_rd_reg <= b_mem[{cur_st, node_reg}];
    end

    // Input buffer; its value and stack are read in the cycle before the weight.
    always_ff @(posedge aclk) begin
        if (in_fire && fill_reg < sdl_pkg::FillW'(sdl_pkg::MaxInputs)) begin
            in_mem[fill_reg[InW-1:0]] <= s_value;
            in_stk[fill_reg[InW-1:0]] <= fs;
        end
        x_rd_reg <= in_mem[jx];
        istk_rd_reg <= in_stk[jx];
        jd_reg <= jx;
        x_b_reg <= x_rd_reg;
    end

    // Node stack choices; an entry never written reads as stack zero.
    always_ff @(posedge aclk) begin
        if (s_fire && s_op == sdl_pkg::OP_STACK)
            nstack[s_node_index[NodeW-1:0]] <= ts;
        stk_rd_reg <= nstack[node_reg];
        stk_ok_reg <= nstack_v_reg[node_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nstack_v_reg <= '0;
        end else if (s_fire && s_op == sdl_pkg::OP_STACK) begin
            nstack_v_reg[s_node_index[NodeW-1:0]] <= 1'b1;
        end
    end

    assign clr = (state_reg == ST_IDLE) || (state_reg == ST_OUT);

    sdl_mac u_mac (
        .aclk (aclk), .clr (clr), .en (rd_v_reg),
        .a (w_rd_reg), .b (x_b_reg), .acc (acc)
    );

    // Sequencer over nodes and inputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            j_reg <= '0;
            node_reg <= '0;
            rd_a_reg <= 1'b0;
            rd_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            rd_a_reg <= (state_reg == ST_MAC) && (j_reg < fill_reg);
            rd_v_reg <= rd_a_reg;
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (s_last) begin
                            node_reg <= '0;
                            j_reg <= '0;
                            if (n_eff == '0) begin
                                fill_reg <= '0;
                            end else begin
                                state_reg <= ST_MAC;
                                if (fill_reg < sdl_pkg::FillW'(sdl_pkg::MaxInputs))
                                    fill_reg <= fill_reg + 1'b1;
                            end
                        end else if (fill_reg < sdl_pkg::FillW'(sdl_pkg::MaxInputs)) begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                    end
                end
                ST_MAC: begin
                    if (j_reg < fill_reg) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        state_reg <= ST_D0;
                    end
                end
                ST_D0: state_reg <= ST_D1;
                ST_D1: state_reg <= ST_D2;
                ST_D2: begin
                    sum_reg <= acc + (AccW'(b_rd_reg) <<< 12) + AccW'(2048);
                    state_reg <= ST_ACT;
                end
                ST_ACT: begin
                    if (!out_v_reg) begin
                        out_v_reg <= 1'b1;
                        out_node_reg <= node_reg;
                        out_last_reg <= (sdl_pkg::NcW'(node_reg) + 1'b1) == n_eff;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    j_reg <= '0;
                    if (out_last_reg) begin
                        fill_reg <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        node_reg <= node_reg + 1'b1;
                        state_reg <= ST_MAC;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    logic signed [AccW-1:0] xq;
    logic signed [15:0] act_val;
    assign xq = sum_reg >>> 12;

    // Activation of the rounded sum.
    always_comb begin
        act_val = sdl_pkg::sat16(xq);
        unique case (act_sel_reg)
            sdl_pkg::ACT_SIGMOID: act_val = 16'(sdl_pkg::plan_sigmoid(xq));
            sdl_pkg::ACT_TANH:
                act_val = 16'((sdl_pkg::plan_sigmoid(xq <<< 1) <<< 1) - 18'sd4096);
            sdl_pkg::ACT_RELU: act_val = xq[AccW-1] ? 16'sd0 : sdl_pkg::sat16(xq);
            default: act_val = sdl_pkg::sat16(xq);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACT && !out_v_reg) act_reg <= act_val;
    end

    assign m_valid = out_v_reg;
    assign m_node_out = 6'(out_node_reg);
    assign m_activation = act_reg;
    assign m_final_res = out_last_reg;

    // The block takes no request while a pass runs.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready) else $error("ready during pass");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= sdl_pkg::FillW'(sdl_pkg::MaxInputs)) else $error("fill overflow");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && !m_ready |=> out_v_reg && $stable(act_reg))
        else $error("result lost");
endmodule
`default_nettype wire

@@ tb/sv/sdl_checker.sv @@
// Checker for the stacked dense layer: mirrors the layer state, predicts node results, compares.
`timescale 1ns / 1ps
module sdl_checker
    import sdl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [1:0]  s_from_stack,
    input  wire logic [1:0]  s_to_stack,
    input  wire logic [5:0]  s_src_index,
    input  wire logic [5:0]  s_node_index,
    input  wire logic signed [15:0] s_value,
    input  wire logic        s_last,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [5:0]  m_node_out,
    input  wire logic signed [15:0] m_activation,
    input  wire logic        m_final_res,
    output int               errors,
    output int               pending,
    output int               checked
);
    typedef struct packed {
        logic [5:0]         node;
        logic signed [15:0] act;
        logic               fin;
    } node_result_t;

    node_result_t       node_results_q[$];
    logic signed [15:0] weight_mem [0:65535];
    logic signed [15:0] bias_mem   [0:255];
    logic [1:0]         node_stk   [0:63];
    logic signed [15:0] in_val     [0:63];
    logic [1:0]         in_stk     [0:63];
    int                 fill;
    logic [1:0]         act_sel;
    logic [6:0]         node_cnt;

    // Piecewise-linear sigmoid on a Q.12 value.
    function automatic longint sigmoid_q12(input longint x);
        longint a;
        longint p;
        a = (x < 0) ? -x : x;
        if (a > 20480) a = 20480;
        if (a >= 20480)     p = 4096;
        else if (a >= 9728) p = (a >> 5) + 3456;
        else if (a >= 4096) p = (a >> 3) + 2560;
        else                p = (a >> 2) + 2048;
        return (x < 0) ? 4096 - p : p;
    endfunction

    function automatic longint clamp_q12(input longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    function automatic longint activate_q12(input longint x);
        case (act_sel)
            ACT_SIGMOID: return sigmoid_q12(x);
            ACT_TANH:    return 2 * sigmoid_q12(2 * x) - 4096;
            ACT_RELU:    return (x < 0) ? 0 : clamp_q12(x);
            default:     return clamp_q12(x);
        endcase
    endfunction

    // One layer pass: accumulate every node over the held inputs.
    task automatic predict_layer();
        int           n;
        longint       acc;
        longint       y;
        logic [1:0]   st;
        node_result_t r;
        n = (node_cnt > 64) ? 64 : int'(node_cnt);
        for (int i = 0; i < n; i++) begin
            st  = node_stk[i];
            acc = 0;
            for (int j = 0; j < fill; j++) begin
                acc += longint'(weight_mem[{in_stk[j], st, 6'(j), 6'(i)}]) *
                       longint'(in_val[j]);
            end
            acc += longint'(bias_mem[{st, 6'(i)}]) * 4096;
            acc = (acc + 2048) >>> 12;
            y = activate_q12(acc);
            r.node = 6'(i);
            r.act  = 16'(y);
            r.fin  = (i + 1 == n);
            node_results_q.push_back(r);
        end
        fill = 0;
    endtask

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
        for (int k = 0; k < 65536; k++) weight_mem[k] = '0;
        for (int k = 0; k < 256; k++) bias_mem[k] = '0;
        for (int k = 0; k < 64; k++) begin
            in_val[k] = '0;
            in_stk[k] = '0;
        end
    end

    // Follow the configuration, the request channel and the result channel.
    always @(posedge aclk) begin
        node_result_t e;
        if (!aresetn) begin
            for (int k = 0; k < 64; k++) node_stk[k] = '0;
            fill     = 0;
            act_sel  = ACT_SIGMOID;
            node_cnt = 7'd64;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ACT) act_sel = cfg_data[1:0];
                else node_cnt = cfg_data;
            end
            if (m_valid && m_ready) begin
                checked++;
                if (node_results_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result node %0d activation %0d", $time,
                             m_node_out, m_activation);
                end else begin
                    e = node_results_q.pop_front();
                    if (m_node_out !== e.node) begin
                        errors++;
                        $display("%0t: node_out expected %0d, got %0d", $time, e.node,
                                 m_node_out);
                    end
                    if (m_activation !== e.act) begin
                        errors++;
                        $display("%0t: node %0d activation expected %0d, got %0d", $time,
                                 e.node, e.act, m_activation);
                    end
                    if (m_final_res !== e.fin) begin
                        errors++;
                        $display("%0t: node %0d final_res expected %0d, got %0d", $time,
                                 e.node, e.fin, m_final_res);
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (s_op)
                    OP_WEIGHT: weight_mem[{s_from_stack, s_to_stack, s_src_index,
                                           s_node_index}] = s_value;
                    OP_BIAS:   bias_mem[{s_to_stack, s_node_index}] = s_value;
                    OP_STACK:  node_stk[s_node_index] = s_to_stack;
                    default: begin
                        if (fill < 64) begin
                            in_val[fill] = s_value;
                            in_stk[fill] = s_from_stack;
                            fill++;
                        end
                        if (s_last) predict_layer();
                    end
                endcase
            end
        end
        pending = node_results_q.size();
    end
endmodule

@@ tb/sv/testbench.sv @@
// Top of the stacked dense layer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import sdl_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [1:0]  s_from_stack;
    logic [1:0]  s_to_stack;
    logic [5:0]  s_src_index;
    logic [5:0]  s_node_index;
    logic signed [15:0] s_value;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_node_out;
    logic signed [15:0] m_activation;
    logic        m_final_res;
    int          errors;
    int          pending;
    int          checked;

    stacked_dense_layer_forward_top uut (.*);

    sdl_checker layer_checker (.*);

    // State of the layer as far as the stimulus needs to know it.
    bit         weight_set [0:65535];
    bit         bias_set   [0:255];
    logic [1:0] stk_mirror [0:63];
    int         count_mirror;
    int         requests_sent;
    int         passes_run;
    int         burst_left;
    bit         offering;
    int         idle_cycles;
    int         results_taken;
    int         rx_left;
    int         rx_mode;
    int         hold_left;
    bit         hold_done;

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: changing stall patterns, and one long hold-off during a big pass.
    always @(posedge aclk) begin
        if (m_valid && m_ready) results_taken++;
        if (!hold_done && results_taken >= 10 && pending >= 20) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_left = $urandom_range(20, 80);
                rx_mode = $urandom_range(0, 2);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog on cycles in which no request of any channel is taken.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 5000) begin
            $display("Timeout at %0t with %0d results outstanding", $time, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_value();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 4095)) - 2048);
    endfunction

    // Offer one request; valid stays up across a burst.
    task automatic send_item(input logic [1:0] op, input logic [1:0] fs,
                             input logic [1:0] ts, input logic [5:0] src,
                             input logic [5:0] node, input logic signed [15:0] val,
                             input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_op         <= op;
        s_from_stack <= fs;
        s_to_stack   <= ts;
        s_src_index  <= src;
        s_node_index <= node;
        s_value      <= val;
        s_last       <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left == 0) s_valid <= 1'b0;
        offering = (burst_left != 0);
        requests_sent++;
        case (op)
            OP_WEIGHT: weight_set[{fs, ts, src, node}] = 1'b1;
            OP_BIAS:   bias_set[{ts, node}] = 1'b1;
            OP_STACK:  stk_mirror[node] = ts;
            default: ;
        endcase
    endtask

    // Drop valid at the end of a sequence so the last request is not repeated.
    task automatic quiesce();
        if (offering) s_valid <= 1'b0;
        offering   = 1'b0;
        burst_left = 0;
    endtask

    // Register write once the layer has delivered everything and settled.
    task automatic write_reg(input logic idx, input logic [6:0] data);
        quiesce();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_COUNT) count_mirror = (data > 64) ? 64 : int'(data);
    endtask

    // One pass: loose writes, pushes, each unwritten weight and bias the pass reads, last push.
    task automatic run_pass(input int inputs, input int noise);
        logic [1:0] push_stk [0:127];
        int         held;
        logic [1:0] st;
        for (int k = 0; k < noise; k++) begin
            send_item(2'($urandom_range(0, 2)), 2'($urandom), 2'($urandom), 6'($urandom),
                      6'($urandom), rand_value(), 1'($urandom));
        end
        for (int j = 0; j < inputs; j++) push_stk[j] = 2'($urandom);
        for (int j = 0; j < inputs - 1; j++) begin
            send_item(OP_PUSH, push_stk[j], 2'($urandom), 6'($urandom), 6'($urandom),
                      rand_value(), 1'b0);
        end
        held = (inputs > 64) ? 64 : inputs;
        for (int i = 0; i < count_mirror; i++) begin
            st = stk_mirror[i];
            if (!bias_set[{st, 6'(i)}])
                send_item(OP_BIAS, 2'($urandom), st, 6'($urandom), 6'(i), rand_value(),
                          1'($urandom));
            for (int j = 0; j < held; j++) begin
                if (!weight_set[{push_stk[j], st, 6'(j), 6'(i)}])
                    send_item(OP_WEIGHT, push_stk[j], st, 6'(j), 6'(i), rand_value(),
                              1'($urandom));
            end
        end
        send_item(OP_PUSH, push_stk[inputs - 1], 2'($urandom), 6'($urandom),
                  6'($urandom), rand_value(), 1'b1);
        passes_run++;
    endtask

    initial begin
        int random_start;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ACT;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_op      = OP_WEIGHT;
        s_from_stack = '0;
        s_to_stack   = '0;
        s_src_index  = '0;
        s_node_index = '0;
        s_value      = '0;
        s_last       = 1'b0;
        m_ready      = 1'b0;
        for (int k = 0; k < 64; k++) stk_mirror[k] = '0;
        count_mirror = 64;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: field extremes, last on writes, every activation.
        write_reg(CFG_ACT, ACT_IDENTITY);
        write_reg(CFG_COUNT, 7'd4);
        send_item(OP_STACK, 2'd0, 2'd3, 6'd0, 6'd1, 16'sd0, 1'b1);
        send_item(OP_WEIGHT, 2'd3, 2'd3, 6'd63, 6'd63, 16'sh7fff, 1'b1);
        send_item(OP_WEIGHT, 2'd0, 2'd0, 6'd0, 6'd0, 16'sh8000, 1'b0);
        send_item(OP_BIAS, 2'd2, 2'd3, 6'd0, 6'd63, 16'sh8000, 1'b0);
        send_item(OP_BIAS, 2'd0, 2'd0, 6'd63, 6'd0, 16'sh7fff, 1'b0);
        run_pass(3, 2);
        write_reg(CFG_ACT, ACT_SIGMOID);
        run_pass(2, 1);
        write_reg(CFG_ACT, ACT_TANH);
        run_pass(2, 1);
        write_reg(CFG_ACT, ACT_RELU);
        run_pass(3, 0);
        // Node count above the bound saturates to all nodes; the receiver holds off here.
        write_reg(CFG_COUNT, 7'd127);
        run_pass(1, 0);
        // These requests wait behind the held results while the input is stalled.
        send_item(OP_BIAS, 2'd1, 2'd2, 6'd5, 6'd40, rand_value(), 1'b0);
        send_item(OP_BIAS, 2'd2, 2'd1, 6'd9, 6'd41, rand_value(), 1'b1);
        // A node count of zero gives a pass with no results.
        write_reg(CFG_COUNT, 7'd0);
        run_pass(1, 0);
        // Pushes past a full buffer are dropped; the last mark still starts the pass.
        write_reg(CFG_COUNT, 7'd1);
        write_reg(CFG_ACT, ACT_IDENTITY);
        run_pass(66, 0);
        write_reg(CFG_COUNT, 7'd1);
        run_pass(1, 1);

        // Random part: small passes, with a register change now and then.
        random_start = requests_sent;
        while (requests_sent - random_start < 40) begin
            if ($urandom_range(0, 3) == 0) write_reg(CFG_ACT, 7'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 9) == 0) write_reg(CFG_COUNT, 7'($urandom));
                else write_reg(CFG_COUNT, 7'($urandom_range(1, 8)));
            end
            run_pass($urandom_range(1, 6), $urandom_range(0, 5));
        end

        quiesce();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Covered %0d requests in %0d layer passes, %0d node results compared,",
                 requests_sent, passes_run, checked);
        $display("across all four activations and node counts from zero to the maximum.");
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
